// ----- rtl/vec3_pkg.sv -----
// ----------------------------------------------------------------------------
// vec3_pkg
// Shared types and constants for the pipelined 3D vector ALU.
// ----------------------------------------------------------------------------
package vec3_pkg;

  localparam int COMP_BITS_DEF = 16;
  localparam int PORT_BITS     = 16;
  localparam int RES_BITS      = 33;
  localparam int QUOT_BITS     = 16;
  localparam int MAG_FRAC      = 16;

  localparam logic [QUOT_BITS-1:0] COS_MAX = 16'h7FFF;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_CROSS = 3'd2,
    OP_DOT   = 3'd3,
    OP_MAG   = 3'd4,
    OP_COS   = 3'd5
  } op_t;

endpackage

// ----- rtl/vector3_alu.sv -----
// ----------------------------------------------------------------------------
// vector3_alu
// Pipelined ALU on two signed 3-component vectors: add, subtract, cross,
// dot, Q.8 magnitude of a, and Q1.15 cosine of the angle between a and b.
// ----------------------------------------------------------------------------
//
//   channel   handshake        payload
//   -------   --------------   ----------------------------------------------
//   command   start / busy     op, a_x, a_y, a_z, b_x, b_y, b_z
//   result    done (strobe)    res_x, res_y, res_z, scalar, zero_length
//
// A word is taken in every cycle in which start is high; busy is always low.
// Every word takes the same latency, set by the square root pipeline,
// which retires one root bit per stage, and the 16-stage cosine divider.
// Reset clears the valid bits of all stages; no result is lost to a stall.
// ----------------------------------------------------------------------------
module vector3_alu
  import vec3_pkg::*;
#(
  parameter int COMP_BITS = COMP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  op,
  input  logic signed [PORT_BITS-1:0] a_x,
  input  logic signed [PORT_BITS-1:0] a_y,
  input  logic signed [PORT_BITS-1:0] a_z,
  input  logic signed [PORT_BITS-1:0] b_x,
  input  logic signed [PORT_BITS-1:0] b_y,
  input  logic signed [PORT_BITS-1:0] b_z,
  output logic                        done,
  output logic signed [RES_BITS-1:0]  res_x,
  output logic signed [RES_BITS-1:0]  res_y,
  output logic signed [RES_BITS-1:0]  res_z,
  output logic signed [RES_BITS-1:0]  scalar,
  output logic                        zero_length
);

  localparam int CW    = COMP_BITS;
  localparam int XW    = (CW > PORT_BITS) ? CW : PORT_BITS;
  localparam int PW    = 2 * CW;
  localparam int SW    = 2 * CW;
  localparam int CRW   = 2 * CW + 1;
  localparam int NW    = 4 * CW;
  localparam int DW    = 2 * CW;
  localparam int RAD_W = (NW > SW + MAG_FRAC) ? NW : SW + MAG_FRAC;
  localparam int RW    = RAD_W / 2;

  typedef struct packed {
    logic                       valid;
    logic                       is_mag;
    logic                       is_cos;
    logic                       zl;
    logic                       neg;
    logic [DW-1:0]              dabs;
    logic signed [RES_BITS-1:0] rx;
    logic signed [RES_BITS-1:0] ry;
    logic signed [RES_BITS-1:0] rz;
    logic signed [RES_BITS-1:0] sc;
  } side_t;

  function automatic logic signed [CW-1:0] comp(input logic [PORT_BITS-1:0] p);
    logic [XW-1:0] e;
    e = XW'(p);
    return signed'(e[CW-1:0]);
  endfunction

  assign busy = 1'b0;

  // Input registers.
  logic                 v0;
  op_t                  op0;
  logic signed [CW-1:0] ax0, ay0, az0, bx0, by0, bz0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    op0 <= op_t'(op);
    ax0 <= comp(a_x);
    ay0 <= comp(a_y);
    az0 <= comp(a_z);
    bx0 <= comp(b_x);
    by0 <= comp(b_y);
    bz0 <= comp(b_z);
  end

  // Products, squares and componentwise sums or differences.
  logic                   v1;
  op_t                    op1;
  logic signed [PW-1:0]   m_xx, m_yy, m_zz, m_yz, m_zy, m_zx, m_xz, m_xy, m_yx;
  logic signed [PW-1:0]   q_ax, q_ay, q_az, q_bx, q_by, q_bz;
  logic signed [CW:0]     vs_x, vs_y, vs_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    op1  <= op0;
    m_xx <= PW'(ax0) * PW'(bx0);
    m_yy <= PW'(ay0) * PW'(by0);
    m_zz <= PW'(az0) * PW'(bz0);
    m_yz <= PW'(ay0) * PW'(bz0);
    m_zy <= PW'(az0) * PW'(by0);
    m_zx <= PW'(az0) * PW'(bx0);
    m_xz <= PW'(ax0) * PW'(bz0);
    m_xy <= PW'(ax0) * PW'(by0);
    m_yx <= PW'(ay0) * PW'(bx0);
    q_ax <= PW'(ax0) * PW'(ax0);
    q_ay <= PW'(ay0) * PW'(ay0);
    q_az <= PW'(az0) * PW'(az0);
    q_bx <= PW'(bx0) * PW'(bx0);
    q_by <= PW'(by0) * PW'(by0);
    q_bz <= PW'(bz0) * PW'(bz0);
    if (op0 == OP_SUB) begin
      vs_x <= (CW+1)'(ax0) - (CW+1)'(bx0);
      vs_y <= (CW+1)'(ay0) - (CW+1)'(by0);
      vs_z <= (CW+1)'(az0) - (CW+1)'(bz0);
    end else begin
      vs_x <= (CW+1)'(ax0) + (CW+1)'(bx0);
      vs_y <= (CW+1)'(ay0) + (CW+1)'(by0);
      vs_z <= (CW+1)'(az0) + (CW+1)'(bz0);
    end
  end

  // Cross terms, dot product and squared lengths.
  logic                  v2;
  op_t                   op2;
  logic signed [CRW-1:0] cx2, cy2, cz2, dot2;
  logic [SW-1:0]         sa2, sb2;
  logic signed [CW:0]    vx2, vy2, vz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    op2  <= op1;
    cx2  <= CRW'(m_yz) - CRW'(m_zy);
    cy2  <= CRW'(m_zx) - CRW'(m_xz);
    cz2  <= CRW'(m_xy) - CRW'(m_yx);
    dot2 <= CRW'(m_xx) + CRW'(m_yy) + CRW'(m_zz);
    sa2  <= $unsigned(q_ax) + $unsigned(q_ay) + $unsigned(q_az);
    sb2  <= $unsigned(q_bx) + $unsigned(q_by) + $unsigned(q_bz);
    vx2  <= vs_x;
    vy2  <= vs_y;
    vz2  <= vs_z;
  end

  // Result selection for the early ops and partial products of |a|^2*|b|^2.
  side_t               side3_next;
  side_t               side3;
  logic [SW-1:0]       sa3;
  logic [2*CW-1:0]     pp_hh, pp_hl, pp_lh, pp_ll;
  logic signed [CRW-1:0] ndot;

  always_comb begin
    ndot              = -dot2;
    side3_next        = '0;
    side3_next.valid  = v2;
    side3_next.is_mag = (op2 == OP_MAG);
    side3_next.is_cos = (op2 == OP_COS);
    side3_next.neg    = dot2[CRW-1];
    side3_next.dabs   = dot2[CRW-1] ? ndot[DW-1:0] : dot2[DW-1:0];
    case (op2)
      OP_ADD, OP_SUB: begin
        side3_next.rx = RES_BITS'(vx2);
        side3_next.ry = RES_BITS'(vy2);
        side3_next.rz = RES_BITS'(vz2);
      end
      OP_CROSS: begin
        side3_next.rx = RES_BITS'(cx2);
        side3_next.ry = RES_BITS'(cy2);
        side3_next.rz = RES_BITS'(cz2);
      end
      OP_DOT: begin
        side3_next.sc = RES_BITS'(dot2);
      end
      OP_MAG: begin
        side3_next.zl = (sa2 == '0);
      end
      OP_COS: begin
        side3_next.zl = (sa2 == '0) || (sb2 == '0);
      end
      default: begin
        side3_next.zl = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side3.valid <= 1'b0;
    end else begin
      side3 <= side3_next;
    end
    sa3   <= sa2;
    pp_hh <= sa2[SW-1:CW] * sb2[SW-1:CW];
    pp_hl <= sa2[SW-1:CW] * sb2[CW-1:0];
    pp_lh <= sa2[CW-1:0] * sb2[SW-1:CW];
    pp_ll <= sa2[CW-1:0] * sb2[CW-1:0];
  end

  // Square root pipeline, one root bit per stage.
  logic [RAD_W-1:0] sq_rad  [0:RW];
  logic [RW+1:0]    sq_rem  [0:RW];
  logic [RW-1:0]    sq_root [0:RW];
  side_t            sq_side [0:RW];
  logic [NW-1:0]    prod4;

  assign prod4 = (NW'(pp_hh) << (2 * CW)) + ((NW'(pp_hl) + NW'(pp_lh)) << CW)
                 + NW'(pp_ll);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_side[0].valid <= 1'b0;
    end else begin
      sq_side[0] <= side3;
    end
    sq_rad[0]  <= side3.is_mag ? (RAD_W'(sa3) << MAG_FRAC) : RAD_W'(prod4);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RW+1:0] cat;
    logic [RW+1:0] trial;
    logic          ge;

    always_comb begin
      cat   = {sq_rem[k][RW-1:0], sq_rad[k][RAD_W-1 -: 2]};
      trial = {sq_root[k], 2'b01};
      ge    = (cat >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_side[k+1].valid <= 1'b0;
      end else begin
        sq_side[k+1] <= sq_side[k];
      end
      sq_rad[k+1]  <= sq_rad[k] << 2;
      sq_rem[k+1]  <= ge ? cat - trial : cat;
      sq_root[k+1] <= {sq_root[k][RW-2:0], ge};
    end
  end

  // Cosine divider: |dot| * 2^15 / root, one quotient bit per stage.
  logic [RW:0]          dv_rem [0:QUOT_BITS];
  logic [QUOT_BITS-1:0] dv_q   [0:QUOT_BITS];
  logic [RW-1:0]        dv_d   [0:QUOT_BITS];
  side_t                dv_side[0:QUOT_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_side[0].valid <= 1'b0;
    end else begin
      dv_side[0] <= sq_side[RW];
    end
    dv_rem[0] <= (RW+1)'(sq_side[RW].dabs);
    dv_q[0]   <= '0;
    dv_d[0]   <= sq_root[RW];
  end

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
    logic [RW:0] sh;
    logic        ge;

    always_comb begin
      if (k == 0) begin
        sh = dv_rem[k];
      end else begin
        sh = {dv_rem[k][RW-1:0], 1'b0};
      end
      ge = (sh >= {1'b0, dv_d[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_side[k+1].valid <= 1'b0;
      end else begin
        dv_side[k+1] <= dv_side[k];
      end
      dv_rem[k+1] <= ge ? sh - {1'b0, dv_d[k]} : sh;
      dv_q[k+1]   <= {dv_q[k][QUOT_BITS-2:0], ge};
      dv_d[k+1]   <= dv_d[k];
    end
  end

  // Output registers.
  side_t                      fin;
  logic [QUOT_BITS-1:0]       qsat;
  logic signed [RES_BITS-1:0] sc_next;

  always_comb begin
    fin  = dv_side[QUOT_BITS];
    qsat = dv_q[QUOT_BITS][QUOT_BITS-1] ? COS_MAX : dv_q[QUOT_BITS];
    if (fin.zl) begin
      sc_next = '0;
    end else if (fin.is_cos) begin
      sc_next = fin.neg ? -RES_BITS'(qsat) : RES_BITS'(qsat);
    end else if (fin.is_mag) begin
      sc_next = RES_BITS'(dv_d[QUOT_BITS]);
    end else begin
      sc_next = fin.sc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
    res_x       <= fin.rx;
    res_y       <= fin.ry;
    res_z       <= fin.rz;
    scalar      <= sc_next;
    zero_length <= fin.zl;
  end

endmodule

// ----- tb/vector3_alu_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector3_alu_checker
// Watches the command and result channels of the vector ALU, computes the
// expected result of every accepted word and compares it field by field.
// ----------------------------------------------------------------------------
module vector3_alu_checker
  import vec3_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [2:0]                  op,
  input  logic signed [PORT_BITS-1:0] a_x,
  input  logic signed [PORT_BITS-1:0] a_y,
  input  logic signed [PORT_BITS-1:0] a_z,
  input  logic signed [PORT_BITS-1:0] b_x,
  input  logic signed [PORT_BITS-1:0] b_y,
  input  logic signed [PORT_BITS-1:0] b_z,
  input  logic                        done,
  input  logic signed [RES_BITS-1:0]  res_x,
  input  logic signed [RES_BITS-1:0]  res_y,
  input  logic signed [RES_BITS-1:0]  res_z,
  input  logic signed [RES_BITS-1:0]  scalar,
  input  logic                        zero_length,
  output int                          errors,
  output int                          pending
);

  typedef struct packed {
    logic [RES_BITS-1:0] x;
    logic [RES_BITS-1:0] y;
    logic [RES_BITS-1:0] z;
    logic [RES_BITS-1:0] s;
    logic                zl;
  } alu_word_t;

  alu_word_t expected_words[$];

  assign pending = expected_words.size();

  function automatic logic [63:0] root_floor(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (128'(c) * 128'(c) <= n) r = c;
    end
    return r;
  endfunction

  function automatic alu_word_t compute_alu(logic [2:0] opc,
      logic signed [15:0] ax, logic signed [15:0] ay, logic signed [15:0] az,
      logic signed [15:0] bx, logic signed [15:0] by, logic signed [15:0] bz);
    longint    rx, ry, rz, sc, dt;
    longint    lax, lay, laz, lbx, lby, lbz;
    logic [63:0] sa, sb, d, q, mag;
    alu_word_t w;
    lax = longint'(ax); lay = longint'(ay); laz = longint'(az);
    lbx = longint'(bx); lby = longint'(by); lbz = longint'(bz);
    rx = 0; ry = 0; rz = 0; sc = 0;
    w.zl = 1'b0;
    sa = lax * lax + lay * lay + laz * laz;
    sb = lbx * lbx + lby * lby + lbz * lbz;
    dt = lax * lbx + lay * lby + laz * lbz;
    case (opc)
      OP_ADD: begin
        rx = lax + lbx; ry = lay + lby; rz = laz + lbz;
      end
      OP_SUB: begin
        rx = lax - lbx; ry = lay - lby; rz = laz - lbz;
      end
      OP_CROSS: begin
        rx = lay * lbz - laz * lby;
        ry = laz * lbx - lax * lbz;
        rz = lax * lby - lay * lbx;
      end
      OP_DOT: sc = dt;
      OP_MAG: begin
        if (sa == 0) w.zl = 1'b1;
        else sc = longint'(root_floor(128'(sa) << 16));
      end
      OP_COS: begin
        if (sa == 0 || sb == 0) begin
          w.zl = 1'b1;
        end else begin
          d = root_floor(128'(sa) * 128'(sb));
          mag = dt < 0 ? 64'(-dt) : 64'(dt);
          q = (mag << 15) / d;
          if (q > 32767) q = 32767;
          sc = dt < 0 ? -longint'(q) : longint'(q);
        end
      end
      default: ;
    endcase
    w.x = rx[RES_BITS-1:0]; w.y = ry[RES_BITS-1:0];
    w.z = rz[RES_BITS-1:0]; w.s = sc[RES_BITS-1:0];
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [RES_BITS-1:0] got,
                                 logic [RES_BITS-1:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    alu_word_t w;
    if (!rst) begin
      if (start && !busy)
        expected_words.push_back(compute_alu(op, a_x, a_y, a_z, b_x, b_y, b_z));
      if (done) begin
        if (expected_words.size() == 0) begin
          $display("%0t result word with nothing expected", $time);
          errors++;
        end else begin
          w = expected_words.pop_front();
          if (res_x !== w.x) report_mismatch("res_x", res_x, w.x);
          if (res_y !== w.y) report_mismatch("res_y", res_y, w.y);
          if (res_z !== w.z) report_mismatch("res_z", res_z, w.z);
          if (scalar !== w.s) report_mismatch("scalar", scalar, w.s);
          if (zero_length !== w.zl)
            report_mismatch("zero_length", RES_BITS'(zero_length), RES_BITS'(w.zl));
        end
      end
    end
  end

endmodule

// ----- tb/vector3_alu_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector3_alu_tb
// Drives directed and random command words with random gaps into the vector
// ALU; the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module vector3_alu_tb;
  import vec3_pkg::*;

  localparam int LATENCY   = 2 * COMP_BITS_DEF + 23;
  localparam int WATCHDOG  = 4000;
  localparam int N_RANDOM  = 1200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, zero_length;
  logic [2:0] op = '0;
  logic signed [PORT_BITS-1:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [PORT_BITS-1:0] b_x = '0, b_y = '0, b_z = '0;
  logic signed [RES_BITS-1:0] res_x, res_y, res_z, scalar;
  int errors, pending, idle_cycles;

  always #5 clk = ~clk;

  vector3_alu i_dut (.*);

  vector3_alu_checker i_checker (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  // Leaves start high so that the next word can follow without a gap.
  task automatic send_word(logic [2:0] o, logic [15:0] ax, logic [15:0] ay,
      logic [15:0] az, logic [15:0] bx, logic [15:0] by, logic [15:0] bz);
    op <= o; a_x <= ax; a_y <= ay; a_z <= az; b_x <= bx; b_y <= by; b_z <= bz;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic random_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 55) n = 0;
    else if (n < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 80);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  initial begin
    logic [15:0] c;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int o = 0; o < 8; o++)
      send_word(3'(o), 16'h7FFF, 16'h8000, 16'h1234, 16'h8000, 16'h8000, 16'h7FFF);
    send_word(OP_MAG, 16'h0, 16'h0, 16'h0, 16'h5, 16'h6, 16'h7);
    send_word(OP_COS, 16'h0, 16'h0, 16'h0, 16'h5, 16'h6, 16'h7);
    send_word(OP_COS, 16'h5, 16'h6, 16'h7, 16'h0, 16'h0, 16'h0);
    send_word(OP_COS, 16'h3, 16'h4, 16'h5, 16'h3, 16'h4, 16'h5);
    send_word(OP_COS, 16'h3, 16'h4, 16'h5, 16'hFFFD, 16'hFFFC, 16'hFFFB);
    send_word(OP_COS, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(OP_MAG, 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0);
    send_word(OP_CROSS, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_word(OP_DOT, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(OP_COS, 16'h1, 16'h0, 16'h0, 16'h0, 16'h1, 16'h0);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      if ($urandom_range(0, 3) != 0) random_gap();
      c = pick_comp();
      if ($urandom_range(0, 7) == 0)
        send_word(OP_COS, c, c, c, -c, c, -c);
      else
        send_word(3'($urandom_range(0, 7)), pick_comp(), pick_comp(), pick_comp(),
                  pick_comp(), pick_comp(), pick_comp());
    end
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
